@@ rtl/bptc_pkg.sv @@
package bptc_pkg;

  // Field and register widths.
  localparam int COEF_W     = 16;
  localparam int RAW_W      = 24;
  localparam int TEMP_W     = 19;
  localparam int PRES_W     = 32;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Internal datapath widths, sized to the value ranges of each term.
  localparam int DT_W    = 25;  // D2 - C5*256
  localparam int TC_W    = 42;  // products of dT with a 17-bit signed coefficient
  localparam int DSQ_W   = 50;  // dT squared
  localparam int TMP_W   = 20;  // temperature terms before the final trim
  localparam int OFF1_W  = 37;  // first-order offset
  localparam int SENS1_W = 36;  // first-order sensitivity
  localparam int COR_W   = 40;  // squares and second-order corrections
  localparam int OFF_W   = 41;  // corrected offset
  localparam int SENS_W  = 40;  // corrected sensitivity
  localparam int LO_W    = 20;  // low slice of the sensitivity for the split product
  localparam int PLO_W   = RAW_W + LO_W;
  localparam int PHI_W   = RAW_W + 1 + SENS_W - LO_W;
  localparam int PROD_W  = 64;
  localparam int PSUM_W  = 44;

  // Shift amounts of the compensation formula.
  localparam int C5_SHIFT   = 8;
  localparam int C2_SHIFT   = 16;
  localparam int C1_SHIFT   = 15;
  localparam int TC_SHIFT   = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int P_SHIFT1   = 21;
  localparam int P_SHIFT2   = 15;

  // Temperature thresholds in hundredths of a degree.
  localparam logic signed [TMP_W-1:0] TEMP_REF      = 20'sd2000;
  localparam logic signed [TMP_W-1:0] TEMP_VERY_LOW = -20'sd1500;
  localparam logic signed [TMP_W-1:0] TEMP_GAP      = TEMP_REF - TEMP_VERY_LOW;
  localparam logic signed [COR_W-1:0] COR_ZERO      = '0;

  // Register map, one word every four bytes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_t;

  // Factory calibration words.
  typedef struct packed {
    logic [COEF_W-1:0] pressure_sensitivity_coef;
    logic [COEF_W-1:0] pressure_offset_coef;
    logic [COEF_W-1:0] sensitivity_temp_coef;
    logic [COEF_W-1:0] offset_temp_coef;
    logic [COEF_W-1:0] reference_temp_coef;
    logic [COEF_W-1:0] temp_sensitivity_coef;
  } cal_t;

endpackage

@@ rtl/bptc_cfg.sv @@
module bptc_cfg import bptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cal_t                  cal
);

  reg_idx_t idx;
  logic     wr;
  logic [COEF_W-1:0] wdata;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign wdata  = pwdata[COEF_W-1:0];
  assign pready = 1'b1;

  // Register writes; addresses past the last word are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr) begin
      case (idx)
        REG_C1: cal.pressure_sensitivity_coef <= wdata;
        REG_C2: cal.pressure_offset_coef      <= wdata;
        REG_C3: cal.sensitivity_temp_coef     <= wdata;
        REG_C4: cal.offset_temp_coef          <= wdata;
        REG_C5: cal.reference_temp_coef       <= wdata;
        REG_C6: cal.temp_sensitivity_coef     <= wdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed word.
  always_comb begin
    case (idx)
      REG_C1:  prdata = APB_DATA_W'(cal.pressure_sensitivity_coef);
      REG_C2:  prdata = APB_DATA_W'(cal.pressure_offset_coef);
      REG_C3:  prdata = APB_DATA_W'(cal.sensitivity_temp_coef);
      REG_C4:  prdata = APB_DATA_W'(cal.offset_temp_coef);
      REG_C5:  prdata = APB_DATA_W'(cal.reference_temp_coef);
      REG_C6:  prdata = APB_DATA_W'(cal.temp_sensitivity_coef);
      default: prdata = '0;
    endcase
  end

endmodule

@@ rtl/baro_pressure_temp_compensation_top.sv @@
// Barometer compensation pipeline. Each item is one raw pressure and one raw
// temperature conversion; the block returns the compensated temperature in
// hundredths of a degree, the pressure in pascal (low 32 bits) and a flag for
// the low-temperature second-order correction. It takes one item per clock
// while the output is not stalled, and each result is produced by the
// nine registered stages: the dT subtract, the dT products, the first-order
// sums, the correction squares, the correction sums, the corrections applied,
// the 24 x 40 bit pressure product split into two partial products, their
// recombination, and the final offset subtract and shift. A stalled output
// holds only the stages behind it that are full; empty stages keep filling.
// The six calibration words are written over the APB port at byte offsets
// 0x00 through 0x14 and should only change while no item is in flight.
module baro_pressure_temp_compensation_top import bptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temperature,
  // Output channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] temperature_centideg,
  output logic signed [PRES_W-1:0] pressure_pa,
  output logic                     second_order_used
);

  localparam int NSTG = 9;

  cal_t cal;

  bptc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  // Stage valid bits and load enables. A stage loads when it is empty or
  // when the stage after it moves on.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: dT = D2 - C5*256.
  logic        [RAW_W-1:0]  s1_d1;
  logic signed [DT_W-1:0]   s1_dt;
  logic signed [DT_W-1:0]   dt_in;

  assign dt_in = $signed({1'b0, raw_temperature})
               - $signed(DT_W'({cal.reference_temp_coef, {C5_SHIFT{1'b0}}}));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d1 <= raw_pressure;
      s1_dt <= dt_in;
    end
  end

  // Stage 2: products of dT with the coefficients and with itself.
  logic        [RAW_W-1:0]  s2_d1;
  logic signed [TC_W-1:0]   s2_tc;
  logic signed [TC_W-1:0]   s2_off;
  logic signed [TC_W-1:0]   s2_sens;
  logic signed [DSQ_W-1:0]  s2_dsq;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_d1   <= s1_d1;
      s2_tc   <= s1_dt * $signed({1'b0, cal.temp_sensitivity_coef});
      s2_off  <= s1_dt * $signed({1'b0, cal.offset_temp_coef});
      s2_sens <= s1_dt * $signed({1'b0, cal.sensitivity_temp_coef});
      s2_dsq  <= s1_dt * s1_dt;
    end
  end

  // Stage 3: first-order temperature, offset and sensitivity, T2, and the
  // deviations from the two thresholds.
  logic        [RAW_W-1:0]   s3_d1;
  logic signed [TMP_W-1:0]   s3_temp;
  logic signed [TMP_W-1:0]   s3_a;
  logic signed [TMP_W-1:0]   s3_b;
  logic signed [TMP_W-1:0]   s3_t2;
  logic signed [OFF1_W-1:0]  s3_off;
  logic signed [SENS1_W-1:0] s3_sens;
  logic                      s3_low;
  logic                      s3_vlow;
  logic signed [TMP_W-1:0]   dev_ref;
  logic signed [TMP_W-1:0]   dev_vlow;

  // TEMP - 2000 is just the shifted product; TEMP + 1500 follows from it.
  assign dev_ref  = TMP_W'(s2_tc >>> TC_SHIFT);
  assign dev_vlow = dev_ref + TEMP_GAP;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_d1   <= s2_d1;
      s3_temp <= dev_ref + TEMP_REF;
      s3_a    <= dev_ref;
      s3_b    <= dev_vlow;
      s3_t2   <= TMP_W'(s2_dsq >>> T2_SHIFT);
      s3_off  <= $signed(OFF1_W'({cal.pressure_offset_coef, {C2_SHIFT{1'b0}}}))
               + OFF1_W'(s2_off >>> OFF_SHIFT);
      s3_sens <= $signed(SENS1_W'({cal.pressure_sensitivity_coef, {C1_SHIFT{1'b0}}}))
               + SENS1_W'(s2_sens >>> SENS_SHIFT);
      s3_low  <= dev_ref[TMP_W-1];
      s3_vlow <= dev_vlow[TMP_W-1];
    end
  end

  // Stage 4: squares of the threshold deviations.
  logic        [RAW_W-1:0]   s4_d1;
  logic signed [TMP_W-1:0]   s4_temp;
  logic signed [TMP_W-1:0]   s4_t2;
  logic signed [OFF1_W-1:0]  s4_off;
  logic signed [SENS1_W-1:0] s4_sens;
  logic signed [COR_W-1:0]   s4_sq;
  logic signed [COR_W-1:0]   s4_sq2;
  logic                      s4_low;
  logic                      s4_vlow;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_d1   <= s3_d1;
      s4_temp <= s3_temp;
      s4_t2   <= s3_t2;
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_sq   <= s3_a * s3_a;
      s4_sq2  <= s3_b * s3_b;
      s4_low  <= s3_low;
      s4_vlow <= s3_vlow;
    end
  end

  // Stage 5: OFF2 and SENS2, with the extra term below -15.00 degrees.
  logic        [RAW_W-1:0]   s5_d1;
  logic signed [TMP_W-1:0]   s5_temp;
  logic signed [TMP_W-1:0]   s5_t2;
  logic signed [OFF1_W-1:0]  s5_off;
  logic signed [SENS1_W-1:0] s5_sens;
  logic signed [COR_W-1:0]   s5_off2;
  logic signed [COR_W-1:0]   s5_sens2;
  logic                      s5_low;
  logic signed [COR_W-1:0]   sq_x5;
  logic signed [COR_W-1:0]   sq2_x7;
  logic signed [COR_W-1:0]   sq2_x11;
  logic signed [COR_W-1:0]   off_extra;
  logic signed [COR_W-1:0]   sens_extra;

  assign sq_x5      = (s4_sq <<< 2) + s4_sq;
  assign sq2_x7     = (s4_sq2 <<< 3) - s4_sq2;
  assign sq2_x11    = (s4_sq2 <<< 3) + (s4_sq2 <<< 1) + s4_sq2;
  assign off_extra  = s4_vlow ? sq2_x7 : COR_ZERO;
  assign sens_extra = s4_vlow ? (sq2_x11 >>> 1) : COR_ZERO;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_d1    <= s4_d1;
      s5_temp  <= s4_temp;
      s5_t2    <= s4_t2;
      s5_off   <= s4_off;
      s5_sens  <= s4_sens;
      s5_off2  <= (sq_x5 >>> 1) + off_extra;
      s5_sens2 <= (sq_x5 >>> 2) + sens_extra;
      s5_low   <= s4_low;
    end
  end

  // Stage 6: apply the second-order corrections below 20.00 degrees.
  logic        [RAW_W-1:0]   s6_d1;
  logic signed [TMP_W-1:0]   s6_temp;
  logic signed [OFF_W-1:0]   s6_off;
  logic signed [SENS_W-1:0]  s6_sens;
  logic                      s6_low;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_d1   <= s5_d1;
      s6_low  <= s5_low;
      if (s5_low) begin
        s6_temp <= s5_temp - s5_t2;
        s6_off  <= OFF_W'(s5_off) - OFF_W'(s5_off2);
        s6_sens <= SENS_W'(s5_sens) - SENS_W'(s5_sens2);
      end else begin
        s6_temp <= s5_temp;
        s6_off  <= OFF_W'(s5_off);
        s6_sens <= SENS_W'(s5_sens);
      end
    end
  end

  // Stage 7: D1 * SENS as two partial products on the sensitivity slices.
  logic signed [TMP_W-1:0]   s7_temp;
  logic signed [OFF_W-1:0]   s7_off;
  logic                      s7_low;
  logic        [PLO_W-1:0]   s7_plo;
  logic signed [PHI_W-1:0]   s7_phi;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_temp <= s6_temp;
      s7_off  <= s6_off;
      s7_low  <= s6_low;
      s7_plo  <= PLO_W'(s6_d1) * PLO_W'(s6_sens[LO_W-1:0]);
      s7_phi  <= $signed({1'b0, s6_d1}) * $signed(s6_sens[SENS_W-1:LO_W]);
    end
  end

  // Stage 8: recombine the partial products.
  logic signed [TMP_W-1:0]   s8_temp;
  logic signed [OFF_W-1:0]   s8_off;
  logic                      s8_low;
  logic signed [PROD_W-1:0]  s8_prod;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_temp <= s7_temp;
      s8_off  <= s7_off;
      s8_low  <= s7_low;
      s8_prod <= (PROD_W'(s7_phi) <<< LO_W) + $signed(PROD_W'(s7_plo));
    end
  end

  // Stage 9: P = ((D1*SENS >> 21) - OFF) >> 15 into the output register.
  logic signed [PSUM_W-1:0] psum;

  assign psum = PSUM_W'(s8_prod >>> P_SHIFT1) - PSUM_W'(s8_off);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      temperature_centideg <= s8_temp[TEMP_W-1:0];
      pressure_pa          <= PRES_W'(psum >>> P_SHIFT2);
      second_order_used    <= s8_low;
    end
  end

  // An accepted item always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item did not enter the first stage");

  // The input stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld) && out_stall)
    else $error("input stalled while the pipeline had room");

  // The very-low-temperature term only appears with the second-order path.
  a_vlow_in_low: assert property (@(posedge clk) disable iff (rst)
    vld[3] && s4_vlow |-> s4_low)
    else $error("extra low-temperature term without second-order correction");

  // Without the correction the temperature is at or above 20.00 degrees.
  a_first_order_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !second_order_used |-> temperature_centideg >= 19'sd2000)
    else $error("first-order result below the reference temperature");

endmodule
